>>> rtl/nrriv_pkg.sv
// Shared types, widths and constants of the RIV codec.
package nrriv_pkg;

  localparam int RIV_W       = 16;
  localparam int RB_W        = 9;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;
  localparam int MAX_BWP_DEF = 275;

  localparam int DIV_STEP    = 4;
  localparam int DIV_STAGES  = RIV_W / DIV_STEP;

  localparam logic [RB_W-1:0] BWP_RESET = RB_W'(275);

  localparam logic CMD_DECODE = 1'b0;
  localparam logic CMD_ENCODE = 1'b1;

  localparam logic REG_BWP_SIZE = 1'b0;

  typedef struct packed {
    logic            cmd;
    logic [RIV_W-1:0] riv_in;
    logic [RB_W-1:0]  length_in;
    logic [RB_W-1:0]  start_in;
  } in_beat_t;

  typedef struct packed {
    logic [RIV_W-1:0] riv_out;
    logic [RB_W-1:0]  length_out;
    logic [RB_W-1:0]  start_out;
    logic             error;
  } out_beat_t;

  typedef struct packed {
    logic             cmd;
    logic [RIV_W-1:0] quot;
    logic [RB_W-1:0]  rem;
  } div_res_t;

  typedef struct packed {
    logic [RIV_W-1:0] riv;
    logic             err;
  } enc_res_t;

endpackage

>>> rtl/nrriv_div.sv
// Pipelined restoring divider: RIV by bandwidth-part size, four quotient bits a stage.
module nrriv_div
  import nrriv_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  in_beat_t        in_data,
  input  logic [RB_W-1:0] divisor,
  output logic            res_vld,
  output div_res_t        res
);

  logic             vld_r   [DIV_STAGES];
  logic             cmd_r   [DIV_STAGES];
  logic [RB_W-1:0]  rem_r   [DIV_STAGES];
  logic [RIV_W-1:0] acc_r   [DIV_STAGES];
  logic [RB_W-1:0]  rem_nxt [DIV_STAGES];
  logic [RIV_W-1:0] acc_nxt [DIV_STAGES];
  logic [RB_W-1:0]  rem_src [DIV_STAGES];
  logic [RIV_W-1:0] acc_src [DIV_STAGES];

  always_comb begin
    rem_src[0] = '0;
    acc_src[0] = in_data.riv_in;
    for (int s = 1; s < DIV_STAGES; s++) begin
      rem_src[s] = rem_r[s-1];
      acc_src[s] = acc_r[s-1];
    end
  end

  always_comb begin
    logic [RB_W-1:0]  rem;
    logic [RIV_W-1:0] acc;
    logic [RB_W:0]    trial;
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem = rem_src[s];
      acc = acc_src[s];
      for (int k = 0; k < DIV_STEP; k++) begin
        trial = {rem, acc[RIV_W-1]};
        acc   = {acc[RIV_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          rem    = RB_W'(trial - {1'b0, divisor});
          acc[0] = 1'b1;
        end else begin
          rem = trial[RB_W-1:0];
        end
      end
      rem_nxt[s] = rem;
      acc_nxt[s] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_vld;
      for (int s = 1; s < DIV_STAGES; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r[0] <= in_data.cmd;
    for (int s = 1; s < DIV_STAGES; s++) begin
      cmd_r[s] <= cmd_r[s-1];
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_r[s] <= rem_nxt[s];
      acc_r[s] <= acc_nxt[s];
    end
  end

  assign res_vld  = vld_r[DIV_STAGES-1];
  assign res.cmd  = cmd_r[DIV_STAGES-1];
  assign res.quot = acc_r[DIV_STAGES-1];
  assign res.rem  = rem_r[DIV_STAGES-1];

endmodule

>>> rtl/nrriv_enc.sv
// Encode pipeline: legality check, multiply, add, zero on error; latency matches the divider.
module nrriv_enc
  import nrriv_pkg::*;
(
  input  logic            clk,
  input  in_beat_t        in_data,
  input  logic [RB_W-1:0] bwp_n,
  output enc_res_t        res
);

  localparam int PROD_W = 2 * RB_W;

  logic              err1_r, err2_r, err3_r;
  logic [RB_W-1:0]   mul1_r, add1_r, add2_r;
  logic [PROD_W-1:0] prod2_r;
  logic [RIV_W-1:0]  sum3_r;
  enc_res_t          res_r;

  logic              err1_nxt, mirror;
  logic [RB_W:0]     span;
  logic [RB_W-1:0]   mul1_nxt, add1_nxt;
  logic [PROD_W-1:0] sum3_full;

  always_comb begin
    span     = {1'b0, in_data.length_in} + {1'b0, in_data.start_in};
    err1_nxt = (in_data.length_in == '0) || (span > {1'b0, bwp_n});
    mirror   = in_data.length_in > (RB_W'(1) + (bwp_n >> 1));
    if (mirror) begin
      mul1_nxt = bwp_n + RB_W'(1) - in_data.length_in;
      add1_nxt = bwp_n - RB_W'(1) - in_data.start_in;
    end else begin
      mul1_nxt = in_data.length_in - RB_W'(1);
      add1_nxt = in_data.start_in;
    end
    sum3_full = prod2_r + PROD_W'(add2_r);
  end

  always_ff @(posedge clk) begin
    err1_r      <= err1_nxt;
    mul1_r      <= mul1_nxt;
    add1_r      <= add1_nxt;
    err2_r      <= err1_r;
    prod2_r     <= PROD_W'(bwp_n) * PROD_W'(mul1_r);
    add2_r      <= add1_r;
    err3_r      <= err2_r;
    sum3_r      <= sum3_full[RIV_W-1:0];
    res_r.err   <= err3_r;
    res_r.riv   <= err3_r ? '0 : sum3_r;
  end

  assign res = res_r;

endmodule

>>> rtl/nr_riv_codec_top.sv
// Top level of the RIV codec: size register, input and output stages, decode fix-up.
//
// Takes one command per cycle; busy never rises. Each result passes the input register
// (loaded at the edge that takes its command), four divider stages of four quotient bits
// each and the output register, and stays for exactly one cycle under out_valid; the
// receiver cannot hold it off. Encode runs beside the divider with the same latency. Write
// bwp_size only while no command is in flight.
module nr_riv_codec_top
  import nrriv_pkg::*;
#(
  parameter int MAX_BWP = MAX_BWP_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_beat_t          in_data,
  output logic              out_valid,
  output out_beat_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [RB_W-1:0] bwp_size_r, n_eff_r, n_eff_nxt;
  logic            in_vld_r;
  in_beat_t        in_data_r;
  logic            out_valid_r;
  out_beat_t       out_data_r, out_data_nxt;
  logic            div_vld;
  div_res_t        div_res;
  enc_res_t        enc_res;
  logic            reg_sel;

  logic            keep;
  logic [RIV_W:0]  ab_sum;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1] == REG_BWP_SIZE;
  assign prdata  = reg_sel ? DATA_W'(bwp_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bwp_size_r <= BWP_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      bwp_size_r <= pwdata[RB_W-1:0];
    end
  end

  always_comb begin
    n_eff_nxt = bwp_size_r;
    if (bwp_size_r == '0) begin
      n_eff_nxt = RB_W'(1);
    end else if (bwp_size_r > RB_W'(MAX_BWP)) begin
      n_eff_nxt = RB_W'(MAX_BWP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_eff_r     <= BWP_RESET;
      in_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      n_eff_r     <= n_eff_nxt;
      in_vld_r    <= start && !busy;
      out_valid_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    in_data_r  <= in_data;
    out_data_r <= out_data_nxt;
  end

  nrriv_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_vld_r),
    .in_data (in_data_r),
    .divisor (n_eff_r),
    .res_vld (div_vld),
    .res     (div_res)
  );

  nrriv_enc u_enc (
    .clk     (clk),
    .in_data (in_data_r),
    .bwp_n   (n_eff_r),
    .res     (enc_res)
  );

  always_comb begin
    ab_sum = {1'b0, div_res.quot} + (RIV_W+1)'(div_res.rem);
    keep   = (div_res.quot <= RIV_W'((n_eff_r >> 1) + RB_W'(1)))
          && (ab_sum < (RIV_W+1)'(n_eff_r));
    out_data_nxt = '0;
    if (div_res.cmd == CMD_ENCODE) begin
      out_data_nxt.riv_out = enc_res.riv;
      out_data_nxt.error   = enc_res.err;
    end else if (keep) begin
      out_data_nxt.length_out = div_res.quot[RB_W-1:0] + RB_W'(1);
      out_data_nxt.start_out  = div_res.rem;
    end else begin
      out_data_nxt.length_out = n_eff_r + RB_W'(1) - div_res.quot[RB_W-1:0];
      out_data_nxt.start_out  = n_eff_r - RB_W'(1) - div_res.rem;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> bench/nr_riv_codec_top_test.sv
// Self-checking bench for the RIV codec: directed table, then random beats against a predictor.
module nr_riv_codec_top_test;
  import nrriv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 10;
  localparam int BEATS_PER_PHASE = 130;
  localparam int NDIR = 23;

  typedef struct packed {
    logic [RB_W-1:0]  sz;
    logic             cmd;
    logic [RIV_W-1:0] riv;
    logic [RB_W-1:0]  len;
    logic [RB_W-1:0]  st;
    logic             typed;
    out_beat_t        want;
  } alloc_row_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  in_beat_t          in_data = '0;
  logic              out_valid;
  out_beat_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  out_beat_t         conv_results_q[$];
  logic [RB_W-1:0]   bwp_size_now = BWP_RESET;
  int                mismatch_cnt = 0;
  int                cycle_cnt = 0;

  alloc_row_t dir_rows [NDIR] = '{
    '{9'd275, CMD_DECODE, 16'd0,     9'd0,   9'd0,   1'b1, '{16'd0,     9'd1,   9'd0,   1'b0}},
    '{9'd275, CMD_DECODE, 16'd274,   9'd0,   9'd0,   1'b1, '{16'd0,     9'd1,   9'd274, 1'b0}},
    '{9'd275, CMD_DECODE, 16'd37949, 9'd0,   9'd0,   1'b1, '{16'd0,     9'd139, 9'd0,   1'b0}},
    '{9'd275, CMD_DECODE, 16'd65535, 9'd0,   9'd0,   1'b1, '{16'd0,     9'd38,  9'd189, 1'b0}},
    '{9'd275, CMD_DECODE, 16'd1234,  9'd0,   9'd0,   1'b0, '0},
    '{9'd275, CMD_ENCODE, 16'd0,     9'd0,   9'd0,   1'b1, '{16'd0,     9'd0,   9'd0,   1'b1}},
    '{9'd275, CMD_ENCODE, 16'd0,     9'd275, 9'd0,   1'b1, '{16'd549,   9'd0,   9'd0,   1'b0}},
    '{9'd275, CMD_ENCODE, 16'd0,     9'd1,   9'd274, 1'b1, '{16'd274,   9'd0,   9'd0,   1'b0}},
    '{9'd275, CMD_ENCODE, 16'd0,     9'd1,   9'd275, 1'b1, '{16'd0,     9'd0,   9'd0,   1'b1}},
    '{9'd275, CMD_ENCODE, 16'hFFFF,  9'd511, 9'd511, 1'b1, '{16'd0,     9'd0,   9'd0,   1'b1}},
    '{9'd275, CMD_ENCODE, 16'd0,     9'd138, 9'd0,   1'b1, '{16'd37675, 9'd0,   9'd0,   1'b0}},
    '{9'd275, CMD_ENCODE, 16'd0,     9'd139, 9'd136, 1'b1, '{16'd37813, 9'd0,   9'd0,   1'b0}},
    '{9'd275, CMD_ENCODE, 16'd0,     9'd100, 9'd50,  1'b0, '0},
    '{9'd0,   CMD_DECODE, 16'd0,     9'd0,   9'd0,   1'b1, '{16'd0,     9'd1,   9'd0,   1'b0}},
    '{9'd0,   CMD_DECODE, 16'd5,     9'd0,   9'd0,   1'b1, '{16'd0,     9'd509, 9'd0,   1'b0}},
    '{9'd0,   CMD_ENCODE, 16'd0,     9'd1,   9'd0,   1'b1, '{16'd0,     9'd0,   9'd0,   1'b0}},
    '{9'd0,   CMD_ENCODE, 16'd0,     9'd1,   9'd1,   1'b1, '{16'd0,     9'd0,   9'd0,   1'b1}},
    '{9'd1,   CMD_DECODE, 16'd65535, 9'h1FF, 9'h1FF, 1'b0, '0},
    '{9'd511, CMD_DECODE, 16'd0,     9'd0,   9'd0,   1'b1, '{16'd0,     9'd1,   9'd0,   1'b0}},
    '{9'd511, CMD_ENCODE, 16'd0,     9'd275, 9'd0,   1'b1, '{16'd549,   9'd0,   9'd0,   1'b0}},
    '{9'd276, CMD_ENCODE, 16'd0,     9'd276, 9'd0,   1'b1, '{16'd0,     9'd0,   9'd0,   1'b1}},
    '{9'd2,   CMD_DECODE, 16'd3,     9'd0,   9'd0,   1'b0, '0},
    '{9'd2,   CMD_ENCODE, 16'd0,     9'd2,   9'd0,   1'b0, '0}
  };

  nr_riv_codec_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned eff_size(logic [RB_W-1:0] sz);
    int unsigned n;
    n = int'(sz);
    if (n == 0) n = 1;
    if (n > MAX_BWP_DEF) n = MAX_BWP_DEF;
    return n;
  endfunction

  function automatic out_beat_t convert_riv(in_beat_t b, logic [RB_W-1:0] sz);
    int unsigned n, quo, rem, l, s;
    out_beat_t o;
    n = eff_size(sz);
    o = '0;
    if (b.cmd == CMD_DECODE) begin
      quo = b.riv_in / n;
      rem = b.riv_in % n;
      if (quo <= (n >> 1) + 1 && quo + rem < n) begin
        o.length_out = RB_W'(quo + 1);
        o.start_out  = RB_W'(rem);
      end else begin
        o.length_out = RB_W'(n + 1 - quo);
        o.start_out  = RB_W'(n - 1 - rem);
      end
    end else begin
      l = int'(b.length_in);
      s = int'(b.start_in);
      if (l == 0 || l + s > n) begin
        o.error = 1'b1;
      end else if (l <= 1 + (n >> 1)) begin
        o.riv_out = RIV_W'(n * (l - 1) + s);
      end else begin
        o.riv_out = RIV_W'(n * (n + 1 - l) + (n - 1 - s));
      end
    end
    return o;
  endfunction

  function automatic in_beat_t gen_alloc(int unsigned n);
    in_beat_t b;
    int unsigned pick, l;
    b.cmd       = 1'($urandom_range(0, 1));
    b.riv_in    = RIV_W'($urandom);
    b.length_in = RB_W'($urandom);
    b.start_in  = RB_W'($urandom);
    pick = $urandom_range(0, 99);
    if (b.cmd == CMD_DECODE) begin
      if (pick < 70) b.riv_in = RIV_W'($urandom_range(0, n * (n + 1) / 2 - 1));
      else if (pick < 90) b.riv_in = RIV_W'($urandom_range(0, n * n - 1));
    end else begin
      if (pick < 75) begin
        l = $urandom_range(1, n);
        b.length_in = RB_W'(l);
        b.start_in  = RB_W'($urandom_range(0, n - l));
      end else if (pick < 82) begin
        b.length_in = '0;
        b.start_in  = RB_W'($urandom_range(0, n));
      end else if (pick < 90) begin
        l = $urandom_range(1, n);
        b.length_in = RB_W'(l);
        b.start_in  = RB_W'(n + 1 - l);
      end
    end
    return b;
  endfunction

  function automatic void check_field(string fname, logic [RIV_W-1:0] want,
                                      logic [RIV_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", fname, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (conv_results_q.size() == 0) begin
        $error("result beat with nothing pending: %h", out_data);
        mismatch_cnt++;
      end else begin
        want = conv_results_q.pop_front();
        check_field("riv_out", want.riv_out, out_data.riv_out);
        check_field("length_out", RIV_W'(want.length_out), RIV_W'(out_data.length_out));
        check_field("start_out", RIV_W'(want.start_out), RIV_W'(out_data.start_out));
        check_field("error", RIV_W'(want.error), RIV_W'(out_data.error));
      end
    end
  end

  task automatic send_beat(in_beat_t b, bit typed, out_beat_t want);
    start   <= 1'b1;
    in_data <= b;
    forever begin
      @(negedge clk);
      if (!busy) break;
      @(posedge clk);
    end
    conv_results_q.push_back(typed ? want : convert_riv(b, bwp_size_now));
    @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (conv_results_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic write_bwp_size(logic [RB_W-1:0] sz, logic [DATA_W-RB_W-1:0] hi);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(REG_BWP_SIZE));
    pwdata  <= {hi, sz};
    @(posedge clk);
    penable <= 1'b1;
    forever begin
      @(negedge clk);
      if (pready) break;
      @(posedge clk);
    end
    @(posedge clk);
    bwp_size_now = sz;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    in_beat_t b;
    alloc_row_t row;
    logic [RB_W-1:0] sz;
    int unsigned n, sent, burst, gap;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.sz != bwp_size_now) write_bwp_size(row.sz, '0);
      b.cmd       = row.cmd;
      b.riv_in    = row.riv;
      b.length_in = row.len;
      b.start_in  = row.st;
      send_beat(b, row.typed, row.want);
    end

    for (int p = 0; p < PHASES; p++) begin
      unique case (p)
        0: sz = 9'd1;
        1: sz = 9'd275;
        2: sz = 9'd0;
        3: sz = 9'd2;
        4: sz = RB_W'($urandom_range(276, 511));
        5: sz = 9'd511;
        default: sz = RB_W'($urandom_range(3, 274));
      endcase
      write_bwp_size(sz, (DATA_W-RB_W)'($urandom));
      n = eff_size(sz);
      sent = 0;
      while (sent < BEATS_PER_PHASE) begin
        burst = $urandom_range(1, 40);
        for (int k = 0; k < burst && sent < BEATS_PER_PHASE; k++) begin
          send_beat(gen_alloc(n), 1'b0, '0);
          sent++;
        end
        if ($urandom_range(0, 3) == 0) gap = 0;
        else gap = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 15 : 3);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    drain_results();
    repeat (2 * PIPE_LAT) @(posedge clk);
    if (mismatch_cnt == 0 && conv_results_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
